FILE: rtl/core/sda_pkg.sv
// sda_pkg: widths, payload words, stage records and register codes for the
// spinor density accumulate pipeline. Depends on nothing; used by every module.
`timescale 1ns / 1ps

package sda_pkg;

  // field widths
  localparam int WAVE_WIDTH    = 16;
  localparam int DENSITY_WIDTH = 32;
  localparam int WEIGHT_WIDTH  = 24;
  localparam int WEIGHT_FRAC   = 16;
  localparam int LANES         = 4;

  // fixed point bookkeeping
  localparam int WAVE_FRAC     = WAVE_WIDTH - 1;
  localparam int DENS_FRAC     = DENSITY_WIDTH - 8;
  localparam int RESCALE_SHIFT = 2 * WAVE_FRAC + WEIGHT_FRAC - DENS_FRAC;
  localparam int SHIFT_R       = (RESCALE_SHIFT > 0) ? RESCALE_SHIFT : 0;
  localparam int SHIFT_L       = (RESCALE_SHIFT < 0) ? -RESCALE_SHIFT : 0;

  localparam int PROD_WIDTH    = 2 * WAVE_WIDTH;
  localparam int TERM_WIDTH    = 2 * WAVE_WIDTH + 3;
  localparam int WPROD_WIDTH   = TERM_WIDTH + WEIGHT_WIDTH + 1;
  localparam int WIDE_WIDTH    = WPROD_WIDTH + SHIFT_L;
  localparam int SCALED_WIDTH  = WPROD_WIDTH - SHIFT_R + SHIFT_L;
  localparam int SUM_WIDTH     =
    ((SCALED_WIDTH > DENSITY_WIDTH) ? SCALED_WIDTH : DENSITY_WIDTH) + 1;

  localparam logic [WPROD_WIDTH-1:0] ROUND_BIAS =
    (SHIFT_R > 0) ? (WPROD_WIDTH'(1) << (SHIFT_R - 1)) : '0;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX =
    SUM_WIDTH'({1'b0, {(DENSITY_WIDTH - 1){1'b1}}});
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = ~SUM_MAX;

  localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE = WEIGHT_WIDTH'(1) << WEIGHT_FRAC;

  // configuration register codes
  localparam int CFG_INDEX_WIDTH = 3;
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_NONCOLLINEAR = 3'd0,
    CFG_FULL_MAG     = 3'd1,
    CFG_Z_ONLY       = 3'd2,
    CFG_WEIGHT       = 3'd3,
    CFG_SPIN         = 3'd4
  } cfg_index_t;

  typedef logic signed [WAVE_WIDTH-1:0]    wave_t;
  typedef logic signed [DENSITY_WIDTH-1:0] dens_t;
  typedef logic signed [PROD_WIDTH-1:0]    prod_t;
  typedef logic signed [TERM_WIDTH-1:0]    term_t;
  typedef logic signed [WPROD_WIDTH-1:0]   wprod_t;

  // input word
  typedef struct packed {
    wave_t up_re;
    wave_t up_im;
    wave_t down_re;
    wave_t down_im;
    dens_t dens_in0;
    dens_t dens_in1;
    dens_t dens_in2;
    dens_t dens_in3;
    logic  last_point;
  } point_t;

  // result word
  typedef struct packed {
    dens_t dens_out0;
    dens_t dens_out1;
    dens_t dens_out2;
    dens_t dens_out3;
    logic  target_spin;
    logic  overflow;
    logic  last_out;
  } result_t;

  // register file contents
  typedef struct packed {
    logic                    noncollinear_mode;
    logic                    full_magnetization;
    logic                    z_magnetization_only;
    logic [WEIGHT_WIDTH-1:0] band_weight;
    logic                    collinear_spin;
  } cfg_t;

  // stage 1: raw component products
  typedef struct packed {
    prod_t            ur_ur;
    prod_t            ui_ui;
    prod_t            dr_dr;
    prod_t            di_di;
    prod_t            ur_dr;
    prod_t            ui_di;
    prod_t            ur_di;
    prod_t            dr_ui;
    dens_t [LANES-1:0] dens;
    logic             last;
  } sq_t;

  // stage 2: per-lane quadratic terms
  typedef struct packed {
    term_t [LANES-1:0] term;
    logic  [LANES-1:0] keep;
    dens_t [LANES-1:0] dens;
    logic              target_spin;
    logic              last;
  } terms_t;

  // stage 3: weighted terms before rescale
  typedef struct packed {
    wprod_t [LANES-1:0] prod;
    logic   [LANES-1:0] keep;
    dens_t  [LANES-1:0] dens;
    logic               target_spin;
    logic               last;
  } wterms_t;

endpackage

FILE: rtl/core/sda_square.sv
// sda_square: first stage, registers the component squares and the up-down cross products.
// Depends on sda_pkg.
`timescale 1ns / 1ps

module sda_square
  import sda_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   src_valid,
  output logic   src_ready,
  input  point_t src,
  output logic   dst_valid,
  input  logic   dst_ready,
  output sq_t    dst
);

  sq_t dst_next;

  assign src_ready = !dst_valid || dst_ready;

  always_comb begin
    dst_next.ur_ur   = PROD_WIDTH'(src.up_re) * PROD_WIDTH'(src.up_re);
    dst_next.ui_ui   = PROD_WIDTH'(src.up_im) * PROD_WIDTH'(src.up_im);
    dst_next.dr_dr   = PROD_WIDTH'(src.down_re) * PROD_WIDTH'(src.down_re);
    dst_next.di_di   = PROD_WIDTH'(src.down_im) * PROD_WIDTH'(src.down_im);
    dst_next.ur_dr   = PROD_WIDTH'(src.up_re) * PROD_WIDTH'(src.down_re);
    dst_next.ui_di   = PROD_WIDTH'(src.up_im) * PROD_WIDTH'(src.down_im);
    dst_next.ur_di   = PROD_WIDTH'(src.up_re) * PROD_WIDTH'(src.down_im);
    dst_next.dr_ui   = PROD_WIDTH'(src.down_re) * PROD_WIDTH'(src.up_im);
    dst_next.dens[0] = src.dens_in0;
    dst_next.dens[1] = src.dens_in1;
    dst_next.dens[2] = src.dens_in2;
    dst_next.dens[3] = src.dens_in3;
    dst_next.last    = src.last_point;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (src_ready) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      dst <= dst_next;
    end
  end

endmodule

FILE: rtl/core/sda_combine.sv
// sda_combine: second stage, forms charge and magnetization terms per mode.
// Depends on sda_pkg.
`timescale 1ns / 1ps

module sda_combine
  import sda_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   src_valid,
  output logic   src_ready,
  input  sq_t    src,
  output logic   dst_valid,
  input  logic   dst_ready,
  output terms_t dst
);

  term_t  nup;
  term_t  ndn;
  term_t  mag_x;
  term_t  mag_y;
  term_t  mag_z;
  terms_t dst_next;

  assign src_ready = !dst_valid || dst_ready;

  always_comb begin
    nup   = TERM_WIDTH'(src.ur_ur) + TERM_WIDTH'(src.ui_ui);
    ndn   = TERM_WIDTH'(src.dr_dr) + TERM_WIDTH'(src.di_di);
    // cross terms carry the exact doubling
    mag_x = (TERM_WIDTH'(src.ur_dr) + TERM_WIDTH'(src.ui_di)) <<< 1;
    mag_y = (TERM_WIDTH'(src.ur_di) - TERM_WIDTH'(src.dr_ui)) <<< 1;
    mag_z = nup - ndn;

    dst_next.term = '0;
    dst_next.keep = '0;
    dst_next.dens = src.dens;
    dst_next.last = src.last;
    dst_next.keep[0] = 1'b1;

    if (!cfg.noncollinear_mode) begin
      // magnetization lanes pass through
      dst_next.term[0]     = nup;
      dst_next.keep        = '1;
      dst_next.target_spin = cfg.collinear_spin;
    end else begin
      dst_next.term[0]     = nup + ndn;
      dst_next.target_spin = 1'b0;
      priority if (cfg.full_magnetization) begin
        dst_next.term[1] = mag_x;
        dst_next.term[2] = mag_y;
        dst_next.term[3] = mag_z;
        dst_next.keep    = '1;
      end else if (cfg.z_magnetization_only) begin
        dst_next.term[3] = mag_z;
        dst_next.keep[3] = 1'b1;
      end else begin
        dst_next.keep[3] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (src_ready) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      dst <= dst_next;
    end
  end

endmodule

FILE: rtl/core/sda_weight.sv
// sda_weight: third stage, multiplies each lane term by the band weight.
// Depends on sda_pkg.
`timescale 1ns / 1ps

module sda_weight
  import sda_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    src_valid,
  output logic    src_ready,
  input  terms_t  src,
  output logic    dst_valid,
  input  logic    dst_ready,
  output wterms_t dst
);

  logic signed [WEIGHT_WIDTH:0] weight_s;
  wterms_t dst_next;

  assign src_ready = !dst_valid || dst_ready;
  assign weight_s  = $signed({1'b0, cfg.band_weight});

  always_comb begin
    dst_next.keep        = src.keep;
    dst_next.dens        = src.dens;
    dst_next.target_spin = src.target_spin;
    dst_next.last        = src.last;
    for (int i = 0; i < LANES; i++) begin
      dst_next.prod[i] = WPROD_WIDTH'($signed(src.term[i])) * WPROD_WIDTH'(weight_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (src_ready) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      dst <= dst_next;
    end
  end

endmodule

FILE: rtl/core/sda_saturate.sv
// sda_saturate: last stage, rounds to density format, adds and saturates.
// Depends on sda_pkg; its register is the block's output register.
`timescale 1ns / 1ps

module sda_saturate
  import sda_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    src_valid,
  output logic    src_ready,
  input  wterms_t src,
  output logic    dst_valid,
  input  logic    dst_ready,
  output result_t dst
);

  logic signed [WPROD_WIDTH-1:0]  rounded  [LANES];
  logic signed [WIDE_WIDTH-1:0]   widened  [LANES];
  logic signed [SCALED_WIDTH-1:0] scaled   [LANES];
  logic signed [SUM_WIDTH-1:0]    sum      [LANES];
  dens_t                          lane_out [LANES];
  logic  [LANES-1:0]              lane_ovf;
  result_t                        dst_next;

  assign src_ready = !dst_valid || dst_ready;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      // half rounds toward plus infinity, then floor shift
      rounded[i] = $signed(src.prod[i]) + $signed(ROUND_BIAS);
      widened[i] = WIDE_WIDTH'(rounded[i]) <<< SHIFT_L;
      scaled[i]  = SCALED_WIDTH'(widened[i] >>> SHIFT_R);
      sum[i]     = SUM_WIDTH'(scaled[i]) + SUM_WIDTH'($signed(src.dens[i]));
      lane_ovf[i] = 1'b0;
      if (!src.keep[i]) begin
        lane_out[i] = '0;
      end else if (sum[i] > SUM_MAX) begin
        lane_out[i] = DENSITY_WIDTH'(SUM_MAX);
        lane_ovf[i] = 1'b1;
      end else if (sum[i] < SUM_MIN) begin
        lane_out[i] = DENSITY_WIDTH'(SUM_MIN);
        lane_ovf[i] = 1'b1;
      end else begin
        lane_out[i] = DENSITY_WIDTH'(sum[i]);
      end
    end
    dst_next.dens_out0   = lane_out[0];
    dst_next.dens_out1   = lane_out[1];
    dst_next.dens_out2   = lane_out[2];
    dst_next.dens_out3   = lane_out[3];
    dst_next.target_spin = src.target_spin;
    dst_next.overflow    = |lane_ovf;
    dst_next.last_out    = src.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (src_ready) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      dst <= dst_next;
    end
  end

endmodule

FILE: rtl/core/spinor_density_accumulate.sv
// spinor_density_accumulate: top level, register file and four-stage pipeline.
// Depends on sda_pkg, sda_square, sda_combine, sda_weight, sda_saturate.
//
//   channel  handshake                 word
//   -------  ------------------------  ---------------------------------
//   point    point_valid/point_ready   point_t: spinor + current densities
//   result   result_valid/result_ready result_t: updated densities, flags
//   cfg      cfg_valid/cfg_ready       cfg_index + cfg_data, always ready
//
// one grid point per cycle while the result port takes; a word passes through four
// register stages on its way to the result port (products, term combine, weight
// multiply, round and saturate, each one register stage)
// every stage has its own valid bit and takes a word when it is empty or its
// successor takes; a stalled result port fills the pipeline from the back
// without loss, and bubbles close up
// synchronous reset clears the valid bits and loads the register defaults
// (band weight 1.0, all flags zero)
`timescale 1ns / 1ps

module spinor_density_accumulate
  import sda_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // grid point words
  input  logic                       point_valid,
  output logic                       point_ready,
  input  point_t                     point,
  // result words
  output logic                       result_valid,
  input  logic                       result_ready,
  output result_t                    result,
  // register writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [WEIGHT_WIDTH-1:0]    cfg_data
);

  cfg_t    cfg;
  cfg_t    cfg_next;

  // stage handshakes
  logic    sq_valid;
  logic    sq_ready;
  sq_t     sq;
  logic    terms_valid;
  logic    terms_ready;
  terms_t  terms;
  logic    wterms_valid;
  logic    wterms_ready;
  wterms_t wterms;

  // register file: always ready; a write to a known index lands in the cycle after it
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_next = cfg;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NONCOLLINEAR: cfg_next.noncollinear_mode    = cfg_data[0];
        CFG_FULL_MAG:     cfg_next.full_magnetization   = cfg_data[0];
        CFG_Z_ONLY:       cfg_next.z_magnetization_only = cfg_data[0];
        CFG_WEIGHT:       cfg_next.band_weight          = cfg_data;
        CFG_SPIN:         cfg_next.collinear_spin       = cfg_data[0];
        default:          cfg_next = cfg;  // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.noncollinear_mode    <= 1'b0;
      cfg.full_magnetization   <= 1'b0;
      cfg.z_magnetization_only <= 1'b0;
      cfg.band_weight          <= WEIGHT_ONE;
      cfg.collinear_spin       <= 1'b0;
    end else begin
      cfg <= cfg_next;
    end
  end

  // stage 1: component products
  sda_square u_square (
    .clk       (clk),
    .rst       (rst),
    .src_valid (point_valid),
    .src_ready (point_ready),
    .src       (point),
    .dst_valid (sq_valid),
    .dst_ready (sq_ready),
    .dst       (sq)
  );

  // stage 2: mode-dependent charge and magnetization terms
  sda_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .src_valid (sq_valid),
    .src_ready (sq_ready),
    .src       (sq),
    .dst_valid (terms_valid),
    .dst_ready (terms_ready),
    .dst       (terms)
  );

  // stage 3: band weight multiply
  sda_weight u_weight (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .src_valid (terms_valid),
    .src_ready (terms_ready),
    .src       (terms),
    .dst_valid (wterms_valid),
    .dst_ready (wterms_ready),
    .dst       (wterms)
  );

  // stage 4: rescale, accumulate, saturate into the output register
  sda_saturate u_saturate (
    .clk       (clk),
    .rst       (rst),
    .src_valid (wterms_valid),
    .src_ready (wterms_ready),
    .src       (wterms),
    .dst_valid (result_valid),
    .dst_ready (result_ready),
    .dst       (result)
  );

endmodule

FILE: tb/sv/sda_density_check.sv
// sda_density_check: watches the point, result and register channels of the
// spinor density accumulator, predicts every result word and compares it.
// Depends on sda_pkg for the word types and register codes.
`timescale 1ns / 1ps

module sda_density_check
  import sda_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       point_valid,
  input  logic                       point_ready,
  input  point_t                     point,
  input  logic                       result_valid,
  input  logic                       result_ready,
  input  result_t                    result,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [WEIGHT_WIDTH-1:0]    cfg_data,
  output int                         mismatches,
  output int                         outstanding,
  output int                         checked
);

  localparam int SCALE_SHIFT = 2 * (WAVE_WIDTH - 1) + WEIGHT_FRAC - (DENSITY_WIDTH - 8);
  localparam int SCALE_DOWN  = (SCALE_SHIFT > 0) ? SCALE_SHIFT : 0;
  localparam int SCALE_UP    = (SCALE_SHIFT < 0) ? -SCALE_SHIFT : 0;
  localparam longint ROUND_HALF = (longint'(1) <<< SCALE_DOWN) >>> 1;
  localparam longint DENS_HI = (longint'(1) <<< (DENSITY_WIDTH - 1)) - 1;
  localparam longint DENS_LO = -DENS_HI - 1;

  // shadow of the register file
  bit                    nc_mode;
  bit                    full_mag;
  bit                    z_only;
  bit                    spin_sel;
  logic [WEIGHT_WIDTH-1:0] weight;

  result_t density_q[$];
  result_t want;

  // weight times a quadratic term, back to density format, half rounds up
  function automatic longint weigh_term(input longint q);
    longint w;
    longint p;
    w = weight;
    p = q * w;
    return ((p + ROUND_HALF) >>> SCALE_DOWN) <<< SCALE_UP;
  endfunction

  function automatic dens_t add_sat(input longint base, input longint add, inout bit ovf);
    longint sum;
    sum = base + add;
    if (sum > DENS_HI) begin
      sum = DENS_HI;
      ovf = 1'b1;
    end
    if (sum < DENS_LO) begin
      sum = DENS_LO;
      ovf = 1'b1;
    end
    return dens_t'(sum);
  endfunction

  function automatic result_t accumulate_point(input point_t p);
    result_t r;
    longint ur, ui, dr, di, nup, ndn;
    bit ovf;
    ur  = longint'($signed(p.up_re));
    ui  = longint'($signed(p.up_im));
    dr  = longint'($signed(p.down_re));
    di  = longint'($signed(p.down_im));
    nup = ur * ur + ui * ui;
    ndn = dr * dr + di * di;
    ovf = 1'b0;
    r   = '0;
    if (!nc_mode) begin
      // down component ignored, magnetization densities pass through
      r.dens_out0   = add_sat(longint'($signed(p.dens_in0)), weigh_term(nup), ovf);
      r.dens_out1   = p.dens_in1;
      r.dens_out2   = p.dens_in2;
      r.dens_out3   = p.dens_in3;
      r.target_spin = spin_sel;
    end else begin
      r.dens_out0 = add_sat(longint'($signed(p.dens_in0)), weigh_term(nup + ndn), ovf);
      if (full_mag) begin
        r.dens_out1 = add_sat(longint'($signed(p.dens_in1)),
                              weigh_term(2 * (ur * dr + ui * di)), ovf);
        r.dens_out2 = add_sat(longint'($signed(p.dens_in2)),
                              weigh_term(2 * (ur * di - dr * ui)), ovf);
        r.dens_out3 = add_sat(longint'($signed(p.dens_in3)), weigh_term(nup - ndn), ovf);
      end else if (z_only) begin
        r.dens_out3 = add_sat(longint'($signed(p.dens_in3)), weigh_term(nup - ndn), ovf);
      end
      r.target_spin = 1'b0;
    end
    r.overflow = ovf;
    r.last_out = p.last_point;
    return r;
  endfunction

  task automatic report_field(input string field,
                              input logic signed [DENSITY_WIDTH-1:0] want_v,
                              input logic signed [DENSITY_WIDTH-1:0] got_v);
    $error("%s: expected %0d, got %0d", field, want_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      nc_mode  = 1'b0;
      full_mag = 1'b0;
      z_only   = 1'b0;
      spin_sel = 1'b0;
      weight   = WEIGHT_ONE;
      density_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NONCOLLINEAR: nc_mode  = cfg_data[0];
          CFG_FULL_MAG:     full_mag = cfg_data[0];
          CFG_Z_ONLY:       z_only   = cfg_data[0];
          CFG_WEIGHT:       weight   = cfg_data;
          CFG_SPIN:         spin_sel = cfg_data[0];
          default: ;
        endcase
      end
      if (point_valid && point_ready)
        density_q.push_back(accumulate_point(point));
      if (result_valid && result_ready) begin
        if (density_q.size() == 0) begin
          $error("result word with no grid point pending: %p", result);
          mismatches++;
        end else begin
          want = density_q.pop_front();
          checked++;
          if (result.dens_out0 !== want.dens_out0)
            report_field("dens_out0", want.dens_out0, result.dens_out0);
          if (result.dens_out1 !== want.dens_out1)
            report_field("dens_out1", want.dens_out1, result.dens_out1);
          if (result.dens_out2 !== want.dens_out2)
            report_field("dens_out2", want.dens_out2, result.dens_out2);
          if (result.dens_out3 !== want.dens_out3)
            report_field("dens_out3", want.dens_out3, result.dens_out3);
          if (result.target_spin !== want.target_spin)
            report_field("target_spin", want.target_spin, result.target_spin);
          if (result.overflow !== want.overflow)
            report_field("overflow", want.overflow, result.overflow);
          if (result.last_out !== want.last_out)
            report_field("last_out", want.last_out, result.last_out);
        end
      end
    end
    outstanding <= density_q.size();
  end

endmodule

FILE: tb/sv/tb.sv
// tb: stimulus and verdict for spinor_density_accumulate; a directed pass over
// every mode and corner, then randomized phases under changing register settings.
// Depends on sda_pkg, the block itself and sda_density_check.
`timescale 1ns / 1ps

module tb;
  import sda_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_PHASES   = 11;
  localparam int PHASE_POINTS    = 100;
  localparam int CFG_FIRST_UNUSED = CFG_SPIN + 1;

  localparam wave_t WAVE_MAX = {1'b0, {(WAVE_WIDTH - 1){1'b1}}};
  localparam wave_t WAVE_MIN = ~WAVE_MAX;
  localparam dens_t DENS_MAX = {1'b0, {(DENSITY_WIDTH - 1){1'b1}}};
  localparam dens_t DENS_MIN = ~DENS_MAX;
  localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MAX = '1;

  // receiver behavior, chosen per phase
  typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC} rx_style_t;

  logic                       clk;
  logic                       rst;
  logic                       point_valid;
  logic                       point_ready;
  point_t                     point_word;
  logic                       result_valid;
  logic                       result_ready;
  result_t                    result_word;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [WEIGHT_WIDTH-1:0]    cfg_data;

  int mismatch_count;
  int pending_words;
  int results_checked;

  // sender pacing
  bit tx_bursty;
  int burst_left;
  int points_sent;
  int cfg_writes;
  int hold_offs;

  // receiver pacing
  rx_style_t rx_style;
  bit        hold_off_req;
  int        hold_left;

  spinor_density_accumulate uut (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .point        (point_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  sda_density_check density_check (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .point        (point_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatch_count),
    .outstanding  (pending_words),
    .checked      (results_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // word builders
  // ---------------------------------------------------------------------------

  function automatic point_t make_point(input wave_t ur, ui, dr, di,
                                        input dens_t d0, d1, d2, d3,
                                        input logic last);
    point_t p;
    p.up_re      = ur;
    p.up_im      = ui;
    p.down_re    = dr;
    p.down_im    = di;
    p.dens_in0   = d0;
    p.dens_in1   = d1;
    p.dens_in2   = d2;
    p.dens_in3   = d3;
    p.last_point = last;
    return p;
  endfunction

  // spinor components lean on the extremes and on tiny values near zero
  function automatic wave_t pick_wave();
    case ($urandom_range(0, 7))
      0:       return WAVE_MAX;
      1:       return WAVE_MIN;
      2:       return '0;
      3:       return wave_t'($urandom_range(0, 6)) - wave_t'(3);
      default: return wave_t'($urandom);
    endcase
  endfunction

  // densities near the rails provoke saturation in both directions
  function automatic dens_t pick_dens();
    case ($urandom_range(0, 9))
      0:       return DENS_MAX;
      1:       return DENS_MIN;
      2:       return '0;
      3:       return DENS_MAX - dens_t'($urandom_range(0, 1 << 26));
      4:       return DENS_MIN + dens_t'($urandom_range(0, 1 << 26));
      default: return dens_t'($urandom);
    endcase
  endfunction

  function automatic point_t random_point();
    return make_point(pick_wave(), pick_wave(), pick_wave(), pick_wave(),
                      pick_dens(), pick_dens(), pick_dens(), pick_dens(),
                      $urandom_range(0, 7) == 0);
  endfunction

  // one-bit registers get junk above bit 0 so the masking is exercised too
  function automatic logic [WEIGHT_WIDTH-1:0] flag_word(input bit f);
    return (WEIGHT_WIDTH'($urandom) & ~WEIGHT_WIDTH'(1)) | WEIGHT_WIDTH'(f);
  endfunction

  // ---------------------------------------------------------------------------
  // channel tasks
  // ---------------------------------------------------------------------------

  // leaves cfg_valid high so writes can go back to back; caller drops it
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [WEIGHT_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
  endtask

  task automatic load_settings(input bit nc, full, z,
                               input logic [WEIGHT_WIDTH-1:0] w,
                               input bit spin, input bit stray);
    if (stray) begin
      // indexes past the register list must be dropped by the block
      for (int i = CFG_FIRST_UNUSED; i < (1 << CFG_INDEX_WIDTH); i++)
        write_reg(CFG_INDEX_WIDTH'(i), WEIGHT_WIDTH'($urandom));
    end
    write_reg(CFG_NONCOLLINEAR, flag_word(nc));
    write_reg(CFG_FULL_MAG, flag_word(full));
    write_reg(CFG_Z_ONLY, flag_word(z));
    write_reg(CFG_WEIGHT, w);
    write_reg(CFG_SPIN, flag_word(spin));
    cfg_valid <= 1'b0;
  endtask

  // valid stays up between words of a burst; a gap lowers it first
  task automatic offer_point(input point_t p);
    int gap;
    if (tx_bursty && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    point_valid <= 1'b1;
    point_word  <= p;
    do @(posedge clk); while (!point_ready);
    if (burst_left > 0)
      burst_left--;
    points_sent++;
  endtask

  // every word yields a result, so an empty prediction queue means idle
  task automatic drain();
    point_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: own stall pattern, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int period_pos;
    period_pos   = 0;
    hold_left    = 0;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_ALWAYS: result_ready <= 1'b1;
          RX_COIN:   result_ready <= ($urandom_range(0, 3) != 0);
          default: begin
            // period_pos counts round modulo 7, and ready is high while it is below 4
            period_pos = (period_pos + 1) % 7;
            result_ready <= (period_pos < 4);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [WEIGHT_WIDTH-1:0] w;
    rst          = 1'b1;
    point_valid  = 1'b0;
    point_word   = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    tx_bursty    = 1'b0;
    burst_left   = 0;
    points_sent  = 0;
    cfg_writes   = 0;
    hold_offs    = 0;
    hold_off_req = 1'b0;
    rx_style     = RX_ALWAYS;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: collinear, weight 1.0, spin array 0
    offer_point(make_point('0, '0, '0, '0, '0, '0, '0, '0, 1'b0));
    offer_point(make_point(WAVE_MAX, WAVE_MAX, WAVE_MIN, WAVE_MIN,
                           DENS_MAX, DENS_MIN, DENS_MAX, DENS_MIN, 1'b0));
    offer_point(make_point(WAVE_MIN, WAVE_MIN, WAVE_MAX, WAVE_MAX,
                           DENS_MIN, '0, '1, DENS_MAX, 1'b1));
    offer_point(make_point('0, WAVE_MIN, '1, '0,
                           pick_dens(), pick_dens(), pick_dens(), pick_dens(), 1'b0));
    drain();

    // collinear with both magnetization flags set: flags must be ignored
    load_settings(1'b0, 1'b1, 1'b1, WEIGHT_MAX, 1'b1, 1'b0);
    rx_style = RX_COIN;
    offer_point(make_point(WAVE_MIN, WAVE_MIN, WAVE_MAX, WAVE_MAX,
                           '0, DENS_MAX, DENS_MIN, '0, 1'b0));
    offer_point(make_point(wave_t'(1), '0, '0, '0, '0, '0, '0, '0, 1'b1));
    offer_point(make_point('1, '0, WAVE_MIN, '0, DENS_MIN, '1, '0, DENS_MAX, 1'b0));
    drain();

    // noncollinear, no magnetization: x, y, z zeroed and never saturated
    load_settings(1'b1, 1'b0, 1'b0, WEIGHT_ONE, 1'b1, 1'b0);
    offer_point(make_point(WAVE_MAX, WAVE_MAX, WAVE_MIN, WAVE_MIN,
                           DENS_MAX, DENS_MAX, DENS_MIN, DENS_MAX, 1'b0));
    offer_point(make_point('0, '0, '0, '0, DENS_MIN, DENS_MIN, DENS_MAX, DENS_MIN, 1'b1));
    drain();

    // z only
    load_settings(1'b1, 1'b0, 1'b1, WEIGHT_ONE, 1'b0, 1'b0);
    offer_point(make_point(WAVE_MAX, WAVE_MAX, '0, '0, '0, DENS_MAX, DENS_MIN, DENS_MAX, 1'b0));
    offer_point(make_point('0, '0, WAVE_MIN, WAVE_MIN, '0, '0, '0, DENS_MIN, 1'b0));
    offer_point(random_point());
    drain();

    // both flags: full magnetization wins
    load_settings(1'b1, 1'b1, 1'b1, WEIGHT_ONE, 1'b0, 1'b0);
    rx_style = RX_PERIODIC;
    offer_point(make_point(WAVE_MAX, WAVE_MAX, WAVE_MAX, WAVE_MIN,
                           '0, '0, '0, '0, 1'b0));
    offer_point(make_point(WAVE_MAX, WAVE_MAX, WAVE_MAX, WAVE_MIN,
                           '0, '0, DENS_MIN, '0, 1'b0));
    offer_point(make_point(WAVE_MIN, WAVE_MIN, WAVE_MIN, WAVE_MIN,
                           DENS_MAX, DENS_MAX, DENS_MAX, DENS_MAX, 1'b0));
    offer_point(make_point(WAVE_MIN, WAVE_MAX, WAVE_MAX, WAVE_MIN,
                           DENS_MIN, DENS_MIN, DENS_MIN, DENS_MIN, 1'b1));
    drain();

    // zero weight, with writes to indexes past the register list first
    load_settings(1'b1, 1'b1, 1'b0, '0, 1'b1, 1'b1);
    offer_point(make_point(WAVE_MIN, WAVE_MAX, WAVE_MIN, WAVE_MAX,
                           DENS_MAX, DENS_MIN, DENS_MAX, DENS_MIN, 1'b0));
    offer_point(random_point());
    drain();
    load_settings(1'b0, 1'b0, 1'b0, '0, 1'b1, 1'b1);
    offer_point(make_point(WAVE_MAX, WAVE_MIN, WAVE_MAX, WAVE_MIN,
                           DENS_MAX, pick_dens(), pick_dens(), pick_dens(), 1'b1));

    // random phases: every mode in turn, weight extremes early on
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0:       w = '0;
        1:       w = WEIGHT_MAX;
        2:       w = WEIGHT_ONE;
        default: begin
          case ($urandom_range(0, 2))
            0:       w = WEIGHT_WIDTH'($urandom_range(0, 1 << (WEIGHT_FRAC + 1)));
            1:       w = WEIGHT_WIDTH'($urandom);
            default: w = WEIGHT_MAX - WEIGHT_WIDTH'($urandom_range(0, 255));
          endcase
        end
      endcase
      case (ph % 4)
        0:       load_settings(1'b0, $urandom_range(0, 1), $urandom_range(0, 1), w,
                               $urandom_range(0, 1), ph == 4);
        1:       load_settings(1'b1, 1'b1, $urandom_range(0, 1), w,
                               $urandom_range(0, 1), 1'b0);
        2:       load_settings(1'b1, 1'b0, 1'b1, w, $urandom_range(0, 1), 1'b0);
        default: load_settings(1'b1, 1'b0, 1'b0, w, $urandom_range(0, 1), 1'b0);
      endcase
      tx_bursty  = (ph % 4 != 3);
      burst_left = 0;
      rx_style   = rx_style_t'(ph % 3);
      if (ph == 5) begin
        // receiver holds off while the sender streams: the pipeline fills
        // and point_ready has to drop
        tx_bursty    = 1'b0;
        hold_off_req = 1'b1;
        hold_offs++;
      end
      repeat (PHASE_POINTS) offer_point(random_point());
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d grid points and %0d register writes, %0d results compared",
             points_sent, cfg_writes, results_checked);
    $display("all modes, weights 0 / 1.0 / max / random, %0d long receiver hold-off(s)",
             hold_offs);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sda_pkg.sv
rtl/core/sda_square.sv
rtl/core/sda_combine.sv
rtl/core/sda_weight.sv
rtl/core/sda_saturate.sv
rtl/core/spinor_density_accumulate.sv
tb/sv/sda_density_check.sv
tb/sv/tb.sv
